### rtl/core/brd_pkg.sv
package brd_pkg;

    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 32;
    localparam int OFFSET_W   = 24;
    localparam int LEN_W      = 8;
    localparam int COL_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MODE  = 2'd2;

    // input commands
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_STREAM  = 1'b1;

    // escape codes following a zero count byte
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    localparam logic [BYTE_W-1:0] HI_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LO_MASK = 8'h0F;

    // palette access for one cycle
    typedef struct packed {
        logic               we;
        logic [BYTE_W-1:0]  wr_idx;
        logic [COLOR_W-1:0] wr_data;
        logic               re;
        logic [BYTE_W-1:0]  rd_idx_a;
        logic [BYTE_W-1:0]  rd_idx_b;
    } t_pal_req;

endpackage

### rtl/core/brd_if.sv
interface brd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [brd_pkg::BYTE_W-1:0]   byte_value;
    logic [brd_pkg::BYTE_W-1:0]   palette_index;
    logic [brd_pkg::COLOR_W-1:0]  palette_color;

    modport source (output valid, command, byte_value, palette_index, palette_color,
                    input ready);
    modport sink   (input valid, command, byte_value, palette_index, palette_color,
                    output ready);
endinterface

interface brd_out_if;
    logic                         valid;
    logic                         ready;
    logic [brd_pkg::OFFSET_W-1:0] pixel_offset;
    logic [brd_pkg::LEN_W-1:0]    run_length;
    logic [brd_pkg::COLOR_W-1:0]  color_first;
    logic [brd_pkg::COLOR_W-1:0]  color_second;
    logic                         image_done;

    modport source (output valid, pixel_offset, run_length, color_first, color_second,
                    image_done, input ready);
    modport sink   (input valid, pixel_offset, run_length, color_first, color_second,
                    image_done, output ready);
endinterface

### rtl/core/bmp_rle_run_decoder_core.sv
// channel   dir  handshake      payload
// i_in_ch   in   valid/ready    command, byte_value, palette_index, palette_color
// o_out_ch  out  valid/ready    pixel_offset, run_length, color_first, color_second,
//                               image_done
// i_cfg_*   in   write enable   register index, write data (no read-back)
//
// One item per cycle while o_out_ch does not stall; a result passes three registered
// stages after its byte is taken: palette read, row * width multiply, range check and
// clip into the output register. Parse state sits in flops, updated by stream bytes.
// Reset is synchronous; the palette is not cleared and is undefined until written.
// i_in_ch.ready drops only while all three stages hold results and o_out_ch stalls.
module bmp_rle_run_decoder_core #(
    parameter int MAX_DIM       = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [brd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [brd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    brd_in_if.sink                            i_in_ch,
    brd_out_if.source                         o_out_ch
);

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int RW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * DW;
    localparam int PW    = RW + DW;
    localparam int OFF_W = ((PW > brd_pkg::COL_W) ? PW : brd_pkg::COL_W) + 1;
    localparam int RDW   = ((RW > brd_pkg::BYTE_W) ? RW : brd_pkg::BYTE_W) + 1;
    localparam int BW    = brd_pkg::BYTE_W;
    localparam int CLW   = brd_pkg::COLOR_W;

    typedef enum logic [5:0] {
        PH_FIRST  = 6'b000001,
        PH_SECOND = 6'b000010,
        PH_DX     = 6'b000100,
        PH_DY     = 6'b001000,
        PH_ABS    = 6'b010000,
        PH_PAD    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic                      v;
        logic                      done;
        logic [brd_pkg::LEN_W-1:0] len;
        logic [RW-1:0]             row;
        logic [brd_pkg::COL_W-1:0] col;
        logic                      zero2;
    } t_s1;

    // configuration
    logic [brd_pkg::CFG_DATA_W-1:0] r_cfg_w;
    logic [brd_pkg::CFG_DATA_W-1:0] r_cfg_h;
    logic                           r_nib;
    logic [DW-1:0]                  r_eff_w;
    logic [AW-1:0]                  r_area;
    logic [DW-1:0]                  w_eff_w;
    logic [DW-1:0]                  w_eff_h;
    logic [DW-1:0]                  w_new_eff_h;

    // parse state
    t_phase                    r_phase,    n_phase;
    logic [BW-1:0]             r_held,     n_held;
    logic [brd_pkg::COL_W-1:0] r_col,      n_col;
    logic [RW-1:0]             r_row,      n_row;
    logic [BW-1:0]             r_abs_left, n_abs_left;
    logic                      r_pad,      n_pad;
    logic                      r_finished, n_finished;

    // pipeline
    t_s1                        r_s1, n_s1;
    logic                       r_s2_v;
    logic                       r_s2_done;
    logic [OFF_W-1:0]           r_s2_off;
    logic [brd_pkg::LEN_W-1:0]  r_s2_len;
    logic [CLW-1:0]             r_s2_c0;
    logic [CLW-1:0]             r_s2_c1;
    logic                       r_out_v;
    logic [brd_pkg::OFFSET_W-1:0] r_out_off;
    logic [brd_pkg::LEN_W-1:0]  r_out_len;
    logic [CLW-1:0]             r_out_c0;
    logic [CLW-1:0]             r_out_c1;
    logic                       r_out_done;

    logic                       w_out_free;
    logic                       w_s2_free;
    logic                       w_s1_free;
    logic                       w_acc;
    logic                       w_stream;
    logic [BW-1:0]              w_b;
    logic [PW-1:0]              w_prod;
    logic                       w_in_range;
    logic [31:0]                w_room;
    logic [CLW-1:0]             w_pal_a;
    logic [CLW-1:0]             w_pal_b;
    brd_pkg::t_pal_req          w_pal_req;
    logic [BW-1:0]              w_nbytes;
    logic                       w_len2;
    logic [RDW-1:0]             w_row_t;
    logic [BW-1:0]              w_down;
    logic                       w_do_down;
    logic                       w_do_done;

    function automatic logic [DW-1:0] eff_dim(input logic [brd_pkg::CFG_DATA_W-1:0] v);
        return (32'(v) > MAX_DIM) ? DW'(MAX_DIM) : DW'(v);
    endfunction

    function automatic logic [brd_pkg::COL_W-1:0] col_add(
        input logic [brd_pkg::COL_W-1:0] c,
        input logic [BW-1:0]             n
    );
        logic [brd_pkg::COL_W:0] s;
        s = {1'b0, c} + (brd_pkg::COL_W + 1)'(n);
        return s[brd_pkg::COL_W] ? brd_pkg::COL_MAX : s[brd_pkg::COL_W-1:0];
    endfunction

    assign w_eff_w     = eff_dim(r_cfg_w);
    assign w_eff_h     = eff_dim(r_cfg_h);
    assign w_new_eff_h = eff_dim(i_cfg_data);

    // handshake chain: each stage moves when the one after it has room
    assign w_out_free = !r_out_v || o_out_ch.ready;
    assign w_s2_free  = !r_s2_v || w_out_free;
    assign w_s1_free  = !r_s1.v || w_s2_free;
    assign i_in_ch.ready = w_s1_free;
    assign w_acc    = i_in_ch.valid && w_s1_free;
    assign w_stream = w_acc && (i_in_ch.command == brd_pkg::CMD_STREAM);
    assign w_b      = i_in_ch.byte_value;

    // parser
    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_col      = r_col;
        n_row      = r_row;
        n_abs_left = r_abs_left;
        n_pad      = r_pad;
        n_finished = r_finished;
        n_s1       = '0;
        n_s1.row   = r_row;
        n_s1.col   = r_col;
        w_pal_req.we       = w_acc && (i_in_ch.command == brd_pkg::CMD_PALETTE);
        w_pal_req.wr_idx   = i_in_ch.palette_index;
        w_pal_req.wr_data  = i_in_ch.palette_color;
        w_pal_req.re       = w_stream;
        w_pal_req.rd_idx_a = w_b;
        w_pal_req.rd_idx_b = w_b;
        w_nbytes   = r_nib ? BW'(({1'b0, w_b} + 9'd1) >> 1) : w_b;
        w_len2     = (r_abs_left >= 8'd2);
        w_down     = 8'd1;
        w_do_down  = 1'b0;
        w_do_done  = 1'b0;
        if (w_stream && !r_finished) begin
            unique case (r_phase)
                PH_FIRST: begin
                    n_held  = w_b;
                    n_phase = PH_SECOND;
                end
                PH_SECOND: begin
                    n_phase = PH_FIRST;
                    if (r_held != '0) begin
                        n_s1.v   = 1'b1;
                        n_s1.len = r_held;
                        if (r_nib) begin
                            w_pal_req.rd_idx_a = (w_b & brd_pkg::HI_MASK) >> 4;
                            w_pal_req.rd_idx_b = w_b & brd_pkg::LO_MASK;
                        end
                        n_col = col_add(r_col, r_held);
                    end else if (w_b == brd_pkg::ESC_EOL) begin
                        n_col     = '0;
                        w_do_down = 1'b1;
                    end else if (w_b == brd_pkg::ESC_EOB) begin
                        w_do_done = 1'b1;
                    end else if (w_b == brd_pkg::ESC_DELTA) begin
                        n_phase = PH_DX;
                    end else begin
                        n_abs_left = w_b;
                        n_pad      = w_nbytes[0];
                        n_phase    = PH_ABS;
                    end
                end
                PH_DX: begin
                    n_held  = w_b;
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    n_phase   = PH_FIRST;
                    n_col     = col_add(r_col, r_held);
                    w_down    = w_b;
                    w_do_down = 1'b1;
                end
                PH_ABS: begin
                    n_s1.v = 1'b1;
                    if (r_nib) begin
                        n_s1.len   = w_len2 ? 8'd2 : 8'd1;
                        n_s1.zero2 = !w_len2;
                        w_pal_req.rd_idx_a = (w_b & brd_pkg::HI_MASK) >> 4;
                        w_pal_req.rd_idx_b = w_b & brd_pkg::LO_MASK;
                        n_col      = col_add(r_col, n_s1.len);
                        n_abs_left = r_abs_left - n_s1.len;
                    end else begin
                        n_s1.len   = 8'd1;
                        n_col      = col_add(r_col, 8'd1);
                        n_abs_left = r_abs_left - 8'd1;
                    end
                    if (n_abs_left == '0) begin
                        n_phase = r_pad ? PH_PAD : PH_FIRST;
                    end
                end
                PH_PAD: begin
                    n_pad   = 1'b0;
                    n_phase = PH_FIRST;
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase
        end
        w_row_t = RDW'(r_row) - RDW'(w_down);
        if (w_do_down) begin
            if (w_row_t[RDW-1]) begin
                w_do_done = 1'b1;
            end else begin
                n_row = RW'(w_row_t);
            end
        end
        if (w_do_done) begin
            n_finished = 1'b1;
            n_phase    = PH_FIRST;
            n_s1.v     = 1'b1;
            n_s1.done  = 1'b1;
        end
    end

    brd_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_req     (w_pal_req),
        .o_color_a (w_pal_a),
        .o_color_b (w_pal_b)
    );

    // configuration and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= 13'd1;
            r_cfg_h    <= 13'd1;
            r_nib      <= 1'b0;
            r_phase    <= PH_FIRST;
            r_held     <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_abs_left <= '0;
            r_pad      <= 1'b0;
            r_finished <= 1'b0;
        end else if (i_cfg_we && (i_cfg_index != brd_pkg::CFG_NIBBLE_MODE + 2'd1)) begin
            unique case (i_cfg_index)
                brd_pkg::CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                brd_pkg::CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                brd_pkg::CFG_NIBBLE_MODE:  r_nib   <= i_cfg_data[0];
                default: ;
            endcase
            r_phase    <= PH_FIRST;
            r_held     <= '0;
            r_col      <= '0;
            r_abs_left <= '0;
            r_pad      <= 1'b0;
            if (i_cfg_index == brd_pkg::CFG_IMAGE_HEIGHT) begin
                r_row      <= RW'(w_new_eff_h - DW'(1));
                r_finished <= (w_new_eff_h == '0);
            end else begin
                r_row      <= RW'(w_eff_h - DW'(1));
                r_finished <= (w_eff_h == '0);
            end
        end else begin
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_col      <= n_col;
            r_row      <= n_row;
            r_abs_left <= n_abs_left;
            r_pad      <= n_pad;
            r_finished <= n_finished;
        end
    end

    // image geometry, registered from the configured width and height registers
    always_ff @(posedge i_clk) begin
        r_eff_w <= w_eff_w;
        r_area  <= AW'(w_eff_w) * AW'(w_eff_h);
    end

    assign w_prod     = PW'(r_s1.row) * PW'(r_eff_w);
    assign w_in_range = (32'(r_s2_off) < 32'(r_area));
    assign w_room     = 32'(r_area) - 32'(r_s2_off);

    // pipeline valids and first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1 <= n_s1;
            end
            if (w_s2_free) begin
                r_s2_v <= r_s1.v;
            end
            if (w_out_free) begin
                r_out_v <= r_s2_v && (r_s2_done || w_in_range);
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_s2_free) begin
            r_s2_done <= r_s1.done;
            r_s2_off  <= OFF_W'(w_prod) + OFF_W'(r_s1.col);
            r_s2_len  <= r_s1.len;
            r_s2_c0   <= r_s1.done ? '0 : w_pal_a;
            r_s2_c1   <= (r_s1.done || r_s1.zero2) ? '0 : w_pal_b;
        end
        if (w_out_free) begin
            if (r_s2_done) begin
                r_out_off  <= '0;
                r_out_len  <= '0;
                r_out_c0   <= '0;
                r_out_c1   <= '0;
                r_out_done <= 1'b1;
            end else begin
                r_out_off  <= brd_pkg::OFFSET_W'(r_s2_off);
                r_out_len  <= (32'(r_s2_len) > w_room) ? brd_pkg::LEN_W'(w_room) : r_s2_len;
                r_out_c0   <= r_s2_c0;
                r_out_c1   <= r_s2_c1;
                r_out_done <= 1'b0;
            end
        end
    end

    assign o_out_ch.valid        = r_out_v;
    assign o_out_ch.pixel_offset = r_out_off;
    assign o_out_ch.run_length   = r_out_len;
    assign o_out_ch.color_first  = r_out_c0;
    assign o_out_ch.color_second = r_out_c1;
    assign o_out_ch.image_done   = r_out_done;

    // once finished, stream bytes must not enter the pipeline
    a_finished_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished && !i_cfg_we && w_stream |=> !r_s1.v)
        else $error("stream byte produced a result after end of image");

    // a run entering the pipeline always carries pixels
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.v && !r_s1.done |-> r_s1.len != '0)
        else $error("zero-length run in pipeline");

    // a stalled first stage keeps its run
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.v && !w_s1_free |=> r_s1.v && $stable(r_s1.len) && $stable(r_s1.col))
        else $error("first stage lost its run while stalled");

    // a delivered run is never empty
    a_out_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out_done |-> r_out_len != '0)
        else $error("empty run delivered");

endmodule

### rtl/core/brd_palette.sv
module brd_palette #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  brd_pkg::t_pal_req             i_req,
    output logic [brd_pkg::COLOR_W-1:0]   o_color_a,
    output logic [brd_pkg::COLOR_W-1:0]   o_color_b
);

    localparam int IW = $clog2(PALETTE_DEPTH);

    logic [IW-1:0]                 w_mod [256];
    logic [brd_pkg::COLOR_W-1:0]   r_mem [PALETTE_DEPTH];
    logic [brd_pkg::COLOR_W-1:0]   r_rd_a;
    logic [brd_pkg::COLOR_W-1:0]   r_rd_b;

    // byte index folded onto the palette depth
    for (genvar g = 0; g < 256; g++) begin : g_mod
        localparam int M = g % PALETTE_DEPTH;
        assign w_mod[g] = IW'(M);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[w_mod[i_req.wr_idx]] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_a <= r_mem[w_mod[i_req.rd_idx_a]];
            r_rd_b <= r_mem[w_mod[i_req.rd_idx_b]];
        end
    end

    assign o_color_a = r_rd_a;
    assign o_color_b = r_rd_b;

endmodule
